/* rtl/sali_pkg.sv */
// ----------------------------------------------------------------------------
// sali_pkg: shared definitions for the setpoint interpolator
// Field widths, command codes, divider request/response structs and the
// saturating add used by the step logic.
// ----------------------------------------------------------------------------
package sali_pkg;

  // axis and field geometry
  localparam int NUM_AXES   = 6;
  localparam int AXIS_W     = 3;
  localparam int LEN_W      = 32;
  localparam int IN_LEN_W   = 31;
  localparam int STEPS_W    = 16;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 8;
  localparam int CMD_W      = 2;

  // serial divider geometry
  localparam int QUO_W     = 32;
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(QUO_W);

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(50);
  localparam logic [STEPS_W-1:0]    MAX_STEPS      = '1;
  localparam logic [AXIS_W-1:0]     AXIS_LAST      = AXIS_W'(NUM_AXES - 1);
  localparam logic [AXIS_W-1:0]     AXIS_COUNT     = AXIS_W'(NUM_AXES);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_STORE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef logic signed [LEN_W-1:0]    len_t;
  typedef logic signed [IN_LEN_W-1:0] in_len_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [QUO_W-1:0]  dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUO_W-1:0]  quotient;
  } div_rsp_t;

  // signed add clamped to the length range
  function automatic len_t sat_add(len_t a, len_t b);
    logic [LEN_W:0] s;
    s = {a[LEN_W-1], a} + {b[LEN_W-1], b};
    if (s[LEN_W] != s[LEN_W-1]) begin
      return s[LEN_W] ? {1'b1, {(LEN_W-1){1'b0}}} : {1'b0, {(LEN_W-1){1'b1}}};
    end
    return len_t'(s[LEN_W-1:0]);
  endfunction

endpackage

/* rtl/sali_in_if.sv */
// ----------------------------------------------------------------------------
// sali_in_if: input item channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface sali_in_if import sali_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [AXIS_W-1:0]      axis;
  in_len_t                target_length;
  in_len_t                measured_length;
  logic [TIME_W-1:0]      duration_ms;
  logic [TIME_W-1:0]      now_ms;

  modport source (
    output valid, command, axis, target_length, measured_length, duration_ms, now_ms,
    input  ready
  );
  modport sink (
    input  valid, command, axis, target_length, measured_length, duration_ms, now_ms,
    output ready
  );
endinterface

/* rtl/sali_out_if.sv */
// ----------------------------------------------------------------------------
// sali_out_if: result channel
// Valid/ready channel carrying one commanded length per beat.
// ----------------------------------------------------------------------------
interface sali_out_if import sali_pkg::*;;
  logic                valid;
  logic                ready;
  logic [AXIS_W-1:0]   out_axis;
  len_t                commanded_length;
  logic [STEPS_W-1:0]  steps_left;
  logic                last;

  modport source (
    output valid, out_axis, commanded_length, steps_left, last,
    input  ready
  );
  modport sink (
    input  valid, out_axis, commanded_length, steps_left, last,
    output ready
  );
endinterface

/* rtl/sali_cfg_if.sv */
// ----------------------------------------------------------------------------
// sali_cfg_if: configuration write channel
// Valid/ready channel carrying the step interval register value.
// ----------------------------------------------------------------------------
interface sali_cfg_if import sali_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [INTERVAL_W-1:0]  step_interval_ms;

  modport source (
    output valid, step_interval_ms,
    input  ready
  );
  modport sink (
    input  valid, step_interval_ms,
    output ready
  );
endinterface

/* rtl/six_axis_linear_setpoint_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// six_axis_linear_setpoint_interpolator_unit: six-axis linear interpolator
// Stores per-axis targets and measurements, turns a start beat into a step
// count and per-step deltas, and emits one setpoint per axis on each step.
// ----------------------------------------------------------------------------
// Store and tick beats are taken while idle; a tick that steps then emits
// six result beats, one per cycle while the result side keeps up.
// A start beat runs the count division (none at a zero interval), then a
// delta division per axis (none at a zero count), on the bit-serial divider.
// No item beat is accepted while a start or a step is in progress.
// Reset is synchronous: stores, setpoints, deltas, count and step time clear,
// the step interval returns to 50 ms.
module six_axis_linear_setpoint_interpolator_unit import sali_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  sali_in_if.sink    items,
  sali_out_if.source results,
  sali_cfg_if.sink   cfg
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CNT_DIV,
    S_AXIS_SETUP,
    S_AXIS_DIV,
    S_EMIT
  } state_t;

  state_t                 state;
  logic [INTERVAL_W-1:0]  interval;
  len_t                   tgt   [NUM_AXES];
  len_t                   meas  [NUM_AXES];
  len_t                   cur   [NUM_AXES];
  len_t                   delta [NUM_AXES];
  logic [STEPS_W-1:0]     steps;
  logic [STEPS_W-1:0]     count;
  logic [TIME_W-1:0]      last_time;
  logic                   force_step;
  logic [AXIS_W-1:0]      idx;
  logic                   neg;

  logic                   out_valid;
  logic [AXIS_W-1:0]      out_axis_r;
  len_t                   out_len_r;
  logic [STEPS_W-1:0]     out_steps_r;
  logic                   out_last_r;

  div_req_t               div_req;
  div_rsp_t               div_rsp;

  len_t                   diff;
  logic [QUO_W-1:0]       mag;
  logic [QUO_W-1:0]       quot_signed;
  logic [STEPS_W-1:0]     count_sat;
  logic [TIME_W-1:0]      elapsed;
  logic                   due;
  len_t                   sum;
  logic                   slot_free;
  logic                   axis_done;
  logic                   emit_fire;

  sali_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // per-axis arithmetic at the current axis index
  always_comb begin
    diff        = tgt[idx] - meas[idx];
    mag         = diff[LEN_W-1] ? QUO_W'(-diff) : QUO_W'(diff);
    quot_signed = neg ? -div_rsp.quotient : div_rsp.quotient;
    count_sat   = (|div_rsp.quotient[QUO_W-1:STEPS_W]) ? MAX_STEPS
                                                       : div_rsp.quotient[STEPS_W-1:0];
    elapsed     = items.now_ms - last_time;
    due         = force_step || (elapsed >= TIME_W'(interval));
    sum         = sat_add(cur[idx], delta[idx]);
    slot_free   = !out_valid || results.ready;
    axis_done   = (idx == AXIS_LAST);
    emit_fire   = (state == S_EMIT) && slot_free;
  end

  // divider launch for the step count and for each axis delta
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = items.duration_ms;
    div_req.divisor  = DIV_W'(interval);
    if (state == S_IDLE) begin
      div_req.start = items.valid && (items.command == CMD_START) && (interval != '0);
    end else if (state == S_AXIS_SETUP) begin
      div_req.start    = (count != '0);
      div_req.dividend = mag;
      div_req.divisor  = count;
    end
  end

  // main sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      interval   <= INTERVAL_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        tgt[i]   <= '0;
        meas[i]  <= '0;
        cur[i]   <= '0;
        delta[i] <= '0;
      end
      steps      <= '0;
      count      <= '0;
      last_time  <= '0;
      force_step <= 1'b0;
      idx        <= '0;
      neg        <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        interval <= cfg.step_interval_ms;
      end
      if (results.ready && !emit_fire) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (items.valid) begin
            case (items.command)
              CMD_STORE: begin
                if (items.axis < AXIS_COUNT) begin
                  tgt[items.axis]  <= LEN_W'(items.target_length);
                  meas[items.axis] <= LEN_W'(items.measured_length);
                end
              end
              CMD_START: begin
                idx <= '0;
                if (interval == '0) begin
                  count <= MAX_STEPS;
                  state <= S_AXIS_SETUP;
                end else begin
                  state <= S_CNT_DIV;
                end
              end
              CMD_TICK: begin
                if (due) begin
                  last_time  <= items.now_ms;
                  force_step <= 1'b0;
                  if (steps != '0) begin
                    steps <= steps - STEPS_W'(1);
                    idx   <= '0;
                    state <= S_EMIT;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        S_CNT_DIV: begin
          if (div_rsp.done) begin
            count <= count_sat;
            state <= S_AXIS_SETUP;
          end
        end

        S_AXIS_SETUP: begin
          cur[idx] <= meas[idx];
          if (count == '0) begin
            delta[idx] <= '0;
            if (axis_done) begin
              steps      <= count;
              last_time  <= '0;
              force_step <= 1'b1;
              state      <= S_IDLE;
            end else begin
              idx <= idx + AXIS_W'(1);
            end
          end else begin
            neg   <= diff[LEN_W-1];
            state <= S_AXIS_DIV;
          end
        end

        S_AXIS_DIV: begin
          if (div_rsp.done) begin
            delta[idx] <= len_t'(quot_signed);
            if (axis_done) begin
              steps      <= count;
              last_time  <= '0;
              force_step <= 1'b1;
              state      <= S_IDLE;
            end else begin
              idx   <= idx + AXIS_W'(1);
              state <= S_AXIS_SETUP;
            end
          end
        end

        S_EMIT: begin
          if (slot_free) begin
            cur[idx]    <= sum;
            out_valid   <= 1'b1;
            out_axis_r  <= idx;
            out_len_r   <= sum;
            out_steps_r <= steps;
            out_last_r  <= axis_done;
            if (axis_done) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + AXIS_W'(1);
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // channel outputs
  assign items.ready              = (state == S_IDLE);
  assign cfg.ready                = 1'b1;
  assign results.valid            = out_valid;
  assign results.out_axis         = out_axis_r;
  assign results.commanded_length = out_len_r;
  assign results.steps_left       = out_steps_r;
  assign results.last             = out_last_r;

endmodule

/* rtl/sali_div.sv */
// ----------------------------------------------------------------------------
// sali_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle, shared by the step count
// and the per-axis delta calculations.
// ----------------------------------------------------------------------------
module sali_div import sali_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [QUO_W-1:0]     dq;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dsr;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  // trial subtract of the next partial remainder
  always_comb begin
    shifted = {rem, dq[QUO_W-1]};
    trial   = shifted - {1'b0, dsr};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(QUO_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - DIV_CNT_W'(1);
        end
      end
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      dq  <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      rem <= trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
      dq  <= {dq[QUO_W-2:0], ~trial[DIV_W]};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

/* rtl/sali_checker.sv */
// ----------------------------------------------------------------------------
// sali_checker: port-level checks for the setpoint interpolator
// Watches the item and result channels for step sequencing slips.
// ----------------------------------------------------------------------------
module sali_checker import sali_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               items_valid,
  input logic               items_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [AXIS_W-1:0]  res_axis,
  input len_t               res_len,
  input logic [STEPS_W-1:0] res_steps,
  input logic               res_last
);

  // a step's beats follow each other in axis order
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=>
      res_valid && (res_axis == AXIS_W'($past(res_axis) + AXIS_W'(1))))
    else $error("step beats out of axis order");

  // the remaining count does not change within a step
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && !res_last |=> res_steps == $past(res_steps))
    else $error("steps_left changed within a step");

  // no item is taken while a step is only partly delivered
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_last |-> !(items_valid && items_ready))
    else $error("item accepted in the middle of a step");

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_len) && $stable(res_axis))
    else $error("stalled result beat changed");

endmodule

bind six_axis_linear_setpoint_interpolator_unit sali_checker u_sali_checker (
  .clk         (clk),
  .rst         (rst),
  .items_valid (items.valid),
  .items_ready (items.ready),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .res_axis    (results.out_axis),
  .res_len     (results.commanded_length),
  .res_steps   (results.steps_left),
  .res_last    (results.last)
);
